// ----- rtl/core/hpfv_pkg.sv -----
// hpfv_pkg: shared types and constants for the hue-preserving full-value core
// no dependencies

package hpfv_pkg;

	localparam int CHAN_W    = 8;
	localparam int CFG_IDX_W = 2;
	localparam int NUM_W     = 17;   // chan * 510 + hi
	localparam int DEN_W     = 9;    // 2 * hi
	localparam int RECIP_W   = 17;   // floor(2^16 / hi)
	localparam int RECIP_SH  = 17;
	localparam int PROD_W    = NUM_W + RECIP_W;
	localparam int RECIP_ONE = 65536;

	localparam logic [CFG_IDX_W-1:0] REG_USE_COLORMAP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIXED_RED    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIXED_GREEN  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FIXED_BLUE   = 2'd3;

	localparam logic [CHAN_W-1:0] CHAN_FULL = 8'hFF;

	typedef struct packed {
		logic              use_colormap;
		logic [CHAN_W-1:0] fixed_red;
		logic [CHAN_W-1:0] fixed_green;
		logic [CHAN_W-1:0] fixed_blue;
	} cfg_t;

	// load enables for the divider lanes, one per stage register
	typedef struct packed {
		logic ld_s3;
		logic ld_s4;
		logic ld_s5;
		logic ld_s6;
	} lane_en_t;

endpackage

// ----- rtl/core/hpfv_cfg_regs.sv -----
// hpfv_cfg_regs: configuration register file of the full-value core
// depends on hpfv_pkg

module hpfv_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [hpfv_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [hpfv_pkg::CHAN_W-1:0]    cfg_wdata,
	output hpfv_pkg::cfg_t                 cfg
);
	import hpfv_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.use_colormap <= 1'b0;
			cfg_q.fixed_red    <= CHAN_FULL;
			cfg_q.fixed_green  <= CHAN_FULL;
			cfg_q.fixed_blue   <= CHAN_FULL;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_USE_COLORMAP: cfg_q.use_colormap <= cfg_wdata[0];
				REG_FIXED_RED:    cfg_q.fixed_red    <= cfg_wdata;
				REG_FIXED_GREEN:  cfg_q.fixed_green  <= cfg_wdata;
				REG_FIXED_BLUE:   cfg_q.fixed_blue   <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/core/hpfv_range.sv -----
// hpfv_range: largest channel and achromatic detect, one register stage
// depends on hpfv_pkg

module hpfv_range (
	input  logic                        clk,
	input  logic                        en,
	input  logic [hpfv_pkg::CHAN_W-1:0] r_s1,
	input  logic [hpfv_pkg::CHAN_W-1:0] g_s1,
	input  logic [hpfv_pkg::CHAN_W-1:0] b_s1,
	output logic [hpfv_pkg::CHAN_W-1:0] hi_s2,
	output logic                        ach_s2
);
	import hpfv_pkg::*;

	logic [CHAN_W-1:0] hi_rg;
	logic [CHAN_W-1:0] lo_rg;
	logic [CHAN_W-1:0] hi;
	logic [CHAN_W-1:0] lo;

	always_comb begin
		hi_rg = (g_s1 > r_s1) ? g_s1 : r_s1;
		lo_rg = (g_s1 < r_s1) ? g_s1 : r_s1;
		hi    = (b_s1 > hi_rg) ? b_s1 : hi_rg;
		lo    = (b_s1 < lo_rg) ? b_s1 : lo_rg;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hi_s2  <= hi;
			ach_s2 <= (hi == lo);
		end
	end

endmodule

// ----- rtl/core/hpfv_recip_rom.sv -----
// hpfv_recip_rom: registered reciprocal table, floor(2^16 / hi), entry zero unused
// depends on hpfv_pkg

module hpfv_recip_rom (
	input  logic                         clk,
	input  logic                         en,
	input  logic [hpfv_pkg::CHAN_W-1:0]  hi_s2,
	output logic [hpfv_pkg::RECIP_W-1:0] recip_s3
);
	import hpfv_pkg::*;

	localparam int DEPTH = 1 << CHAN_W;

	logic [RECIP_W-1:0] rom [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_rom
		localparam logic [RECIP_W-1:0] ENTRY = (i == 0) ? '0 : RECIP_W'(RECIP_ONE / i);
		assign rom[i] = ENTRY;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			recip_s3 <= rom[hi_s2];
		end
	end

endmodule

// ----- rtl/core/hpfv_div_lane.sv -----
// hpfv_div_lane: one channel of round(chan * 255 / hi) by reciprocal multiply
// and a single correction step; depends on hpfv_pkg

module hpfv_div_lane (
	input  logic                         clk,
	input  logic                         arst_n,
	input  hpfv_pkg::lane_en_t           en,
	input  logic [hpfv_pkg::CHAN_W-1:0]  chan_s2,
	input  logic [hpfv_pkg::CHAN_W-1:0]  hi_s2,
	input  logic [hpfv_pkg::RECIP_W-1:0] recip_s3,
	output logic [hpfv_pkg::CHAN_W-1:0]  q_s6
);
	import hpfv_pkg::*;

	logic [NUM_W-1:0]  num_s3, num_s4, num_s5;
	logic [DEN_W-1:0]  den_s3, den_s4, den_s5;
	logic [PROD_W-1:0] prod_s4;
	logic [CHAN_W-1:0] qe_s5;
	logic [NUM_W-1:0]  qd_s5;
	logic [NUM_W-1:0]  rem_s5;

	// numerator chan * 510 + hi, denominator 2 * hi
	always_ff @(posedge clk) begin
		if (en.ld_s3) begin
			num_s3 <= {chan_s2, 9'b0} - {8'b0, chan_s2, 1'b0} + {9'b0, hi_s2};
			den_s3 <= {hi_s2, 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en.ld_s4) begin
			prod_s4 <= PROD_W'(num_s3) * PROD_W'(recip_s3);
			num_s4  <= num_s3;
			den_s4  <= den_s3;
		end
	end

	// estimate is the true quotient or one below it
	always_ff @(posedge clk) begin
		if (en.ld_s5) begin
			qe_s5  <= prod_s4[RECIP_SH +: CHAN_W];
			qd_s5  <= NUM_W'(prod_s4[RECIP_SH +: CHAN_W]) * NUM_W'(den_s4);
			num_s5 <= num_s4;
			den_s5 <= den_s4;
		end
	end

	assign rem_s5 = num_s5 - qd_s5;

	always_ff @(posedge clk) begin
		if (en.ld_s6) begin
			q_s6 <= qe_s5 + CHAN_W'(rem_s5 >= NUM_W'(den_s5));
		end
	end

	a_est_fits: assert property (@(posedge clk) disable iff (!arst_n)
		en.ld_s5 |-> prod_s4[PROD_W-1:RECIP_SH+CHAN_W] == '0)
		else $error("quotient estimate overflows a channel");

	a_est_not_high: assert property (@(posedge clk) disable iff (!arst_n)
		en.ld_s6 |-> qd_s5 <= num_s5)
		else $error("quotient estimate above true quotient");

	// a black pixel has a zero denominator and its quotient is never used
	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		en.ld_s6 && (den_s5 != '0) |-> rem_s5 < (NUM_W'(den_s5) << 1))
		else $error("quotient estimate needs more than one correction");

endmodule

// ----- rtl/core/rgb_hue_preserving_full_value_core.sv -----
// rgb_hue_preserving_full_value_core: top level, pipeline control and output select
// depends on hpfv_pkg, hpfv_cfg_regs, hpfv_range, hpfv_recip_rom, hpfv_div_lane

// One pixel is taken every clock at which start is high; busy is always low, so
// pixels may arrive back to back without gaps. Each pixel's foreground colour
// appears on out_red/out_green/out_blue with done high for a single cycle, in
// input order; there is no backpressure, so the receiver must take every result
// in its cycle. The input register is followed by the registers of the divide
// path: range detect, reciprocal table lookup, a 17x17 multiply, a check
// multiply, a correction add and the output select, one register each.
// Configuration writes are registered and should be made with no pixel in
// flight; use_colormap is sampled as each pixel enters.

module rgb_hue_preserving_full_value_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [hpfv_pkg::CHAN_W-1:0]    src_red,
	input  logic [hpfv_pkg::CHAN_W-1:0]    src_green,
	input  logic [hpfv_pkg::CHAN_W-1:0]    src_blue,
	output logic                           done,
	output logic [hpfv_pkg::CHAN_W-1:0]    out_red,
	output logic [hpfv_pkg::CHAN_W-1:0]    out_green,
	output logic [hpfv_pkg::CHAN_W-1:0]    out_blue,
	input  logic                           cfg_we,
	input  logic [hpfv_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [hpfv_pkg::CHAN_W-1:0]    cfg_wdata
);
	import hpfv_pkg::*;

	cfg_t cfg;
	logic accept;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic cm_s1, cm_s2, cm_s3, cm_s4, cm_s5, cm_s6, cm_s7;
	logic ach_s2, ach_s3, ach_s4, ach_s5, ach_s6;

	logic [CHAN_W-1:0] r_s1, g_s1, b_s1;
	logic [CHAN_W-1:0] r_s2, g_s2, b_s2;
	logic [CHAN_W-1:0] hi_s2;
	logic [RECIP_W-1:0] recip_s3;
	logic [CHAN_W-1:0] qr_s6, qg_s6, qb_s6;
	logic [CHAN_W-1:0] out_red_s7, out_green_s7, out_blue_s7;

	lane_en_t lane_en;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	hpfv_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// valid and mode travel with each beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			r_s1  <= src_red;
			g_s1  <= src_green;
			b_s1  <= src_blue;
			cm_s1 <= cfg.use_colormap;
		end
		if (v_s1) begin
			r_s2  <= r_s1;
			g_s2  <= g_s1;
			b_s2  <= b_s1;
			cm_s2 <= cm_s1;
		end
		if (v_s2) begin
			cm_s3  <= cm_s2;
			ach_s3 <= ach_s2;
		end
		if (v_s3) begin
			cm_s4  <= cm_s3;
			ach_s4 <= ach_s3;
		end
		if (v_s4) begin
			cm_s5  <= cm_s4;
			ach_s5 <= ach_s4;
		end
		if (v_s5) begin
			cm_s6  <= cm_s5;
			ach_s6 <= ach_s5;
		end
	end

	hpfv_range u_range (
		.clk    (clk),
		.en     (v_s1),
		.r_s1   (r_s1),
		.g_s1   (g_s1),
		.b_s1   (b_s1),
		.hi_s2  (hi_s2),
		.ach_s2 (ach_s2)
	);

	hpfv_recip_rom u_rom (
		.clk      (clk),
		.en       (v_s2),
		.hi_s2    (hi_s2),
		.recip_s3 (recip_s3)
	);

	assign lane_en.ld_s3 = v_s2;
	assign lane_en.ld_s4 = v_s3;
	assign lane_en.ld_s5 = v_s4;
	assign lane_en.ld_s6 = v_s5;

	hpfv_div_lane u_lane_r (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (lane_en),
		.chan_s2  (r_s2),
		.hi_s2    (hi_s2),
		.recip_s3 (recip_s3),
		.q_s6     (qr_s6)
	);

	hpfv_div_lane u_lane_g (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (lane_en),
		.chan_s2  (g_s2),
		.hi_s2    (hi_s2),
		.recip_s3 (recip_s3),
		.q_s6     (qg_s6)
	);

	hpfv_div_lane u_lane_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (lane_en),
		.chan_s2  (b_s2),
		.hi_s2    (hi_s2),
		.recip_s3 (recip_s3),
		.q_s6     (qb_s6)
	);

	// output select: fixed colour, white for gray pixels, else scaled channels
	always_ff @(posedge clk) begin
		if (v_s6) begin
			cm_s7 <= cm_s6;
			if (!cm_s6) begin
				out_red_s7   <= cfg.fixed_red;
				out_green_s7 <= cfg.fixed_green;
				out_blue_s7  <= cfg.fixed_blue;
			end else if (ach_s6) begin
				out_red_s7   <= CHAN_FULL;
				out_green_s7 <= CHAN_FULL;
				out_blue_s7  <= CHAN_FULL;
			end else begin
				out_red_s7   <= qr_s6;
				out_green_s7 <= qg_s6;
				out_blue_s7  <= qb_s6;
			end
		end
	end

	assign done      = v_s7;
	assign out_red   = out_red_s7;
	assign out_green = out_green_s7;
	assign out_blue  = out_blue_s7;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##7 done)
		else $error("accepted beat did not come out after fixed latency");

	a_fixed_colour: assert property (@(posedge clk) disable iff (!arst_n)
		done && !cm_s7 |-> out_red == $past(cfg.fixed_red) &&
			out_green == $past(cfg.fixed_green) && out_blue == $past(cfg.fixed_blue))
		else $error("fixed foreground not delivered with mapping off");

	a_full_value: assert property (@(posedge clk) disable iff (!arst_n)
		done && cm_s7 |-> out_red == CHAN_FULL || out_green == CHAN_FULL ||
			out_blue == CHAN_FULL)
		else $error("mapped colour has no channel at full value");

endmodule
